// ===== hw/rtl/fcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcfp_pkg
// Shared constants and types for the float channel frame parser.
// ----------------------------------------------------------------------------
package fcfp_pkg;

  // Channel buffer depth in 32-bit words (1..31)
  localparam int MAX_CHANNELS = 20;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int CH_IDX_W = 5;
  localparam int POS_W    = 7;
  localparam int LANE_W   = 2;
  localparam int LANES    = WORD_W / BYTE_W;

  // Word address width into the channel buffer
  localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Frame open marker ('$')
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h24;

  // Buffer depth as a channel count
  localparam logic [CH_IDX_W-1:0] MAX_CH = CH_IDX_W'(MAX_CHANNELS);

  // Byte write into the channel buffer
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [LANE_W-1:0] lane;
    logic [BYTE_W-1:0] data;
  } buf_wr_t;

  // Word read from the channel buffer
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } buf_rd_t;

endpackage

// ===== hw/rtl/fcfp_word_buf.sv =====
// ----------------------------------------------------------------------------
// fcfp_word_buf
// Channel word buffer: byte-lane writes, one registered word read per cycle.
// ----------------------------------------------------------------------------
module fcfp_word_buf (
  input  logic                            clk,
  input  fcfp_pkg::buf_wr_t               wr,
  input  fcfp_pkg::buf_rd_t               rd,
  output logic [fcfp_pkg::WORD_W-1:0]     rd_data
);
  import fcfp_pkg::*;

  logic [LANES-1:0][BYTE_W-1:0] mem [MAX_CHANNELS];
  logic [WORD_W-1:0]            rd_data_r;

  // Byte write; little-endian lane order
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr][wr.lane] <= wr.data;
    end
  end

  // Registered word read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/float_channel_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// float_channel_frame_parser_top
// Assembles '$'-started frames of little-endian 32-bit channel words and
// emits the stored words in order once a frame terminator arrives.
// ----------------------------------------------------------------------------
//  Channel | Ports                                           | Dir
//  --------+-------------------------------------------------+----
//  input   | in_valid, in_ready, in_rx_byte[7:0]             | in
//  result  | out_valid, out_ready, out_channel_index[4:0],   | out
//          | out_value_bits[31:0], out_last_channel          |
//
// A byte that causes no result is accepted while the block stays idle and
// ready. A terminator byte starts a burst of n words, each word being read
// from the buffer (ST_READ) and then held on the output (ST_SEND) until
// out_ready; in_ready is low for the whole burst. The sequencer fetches the
// next word only after the previous one is taken. Reset (rst_n low,
// synchronous) closes any open frame; the buffer contents are not cleared.
// ----------------------------------------------------------------------------
module float_channel_frame_parser_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fcfp_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fcfp_pkg::CH_IDX_W-1:0]     out_channel_index,
  output logic [fcfp_pkg::WORD_W-1:0]       out_value_bits,
  output logic                              out_last_channel
);
  import fcfp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  state_t                state_r, state_nxt;
  logic                  in_frame_r, in_frame_nxt;
  logic [POS_W-1:0]      byte_pos_r, byte_pos_nxt;
  logic [CH_IDX_W-1:0]   n_r, n_nxt;
  logic [CH_IDX_W-1:0]   k_r, k_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  last_r, last_nxt;

  logic                  accept;
  logic                  is_start;
  logic [POS_W-1:0]      pos;
  logic [CH_IDX_W-1:0]   word_idx;
  logic                  is_term;
  logic                  is_ovf;
  buf_wr_t               wr;
  buf_rd_t               rd;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Decode of the incoming byte against the current position
  assign is_start = (in_rx_byte == SYNC_BYTE);
  assign pos      = byte_pos_r + POS_W'(1);
  assign word_idx = byte_pos_r[POS_W-1:LANE_W];
  assign is_term  = (byte_pos_r[LANE_W-1:0] == '0) && (word_idx != '0) &&
                    (in_rx_byte == {1'b0, pos});
  assign is_ovf   = (word_idx >= MAX_CH);

  // Data byte store
  always_comb begin
    wr.en   = accept && !is_start && in_frame_r && !is_term && !is_ovf;
    wr.addr = byte_pos_r[ADDR_W+LANE_W-1:LANE_W];
    wr.lane = byte_pos_r[LANE_W-1:0];
    wr.data = in_rx_byte;
  end

  // Word fetch for the emission burst
  always_comb begin
    rd.en   = (state_r == ST_READ);
    rd.addr = k_r[ADDR_W-1:0];
  end

  fcfp_word_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (out_value_bits)
  );

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    in_frame_nxt  = in_frame_r;
    byte_pos_nxt  = byte_pos_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    last_nxt      = last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_start) begin
            in_frame_nxt = 1'b1;
            byte_pos_nxt = '0;
          end else if (in_frame_r) begin
            if (is_term) begin
              in_frame_nxt = 1'b0;
              byte_pos_nxt = '0;
              if (word_idx <= MAX_CH) begin
                n_nxt     = word_idx;
                k_nxt     = '0;
                state_nxt = ST_READ;
              end
            end else if (is_ovf) begin
              // frame too long: drop it
              in_frame_nxt = 1'b0;
              byte_pos_nxt = '0;
            end else begin
              byte_pos_nxt = pos;
            end
          end
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        last_nxt      = (k_r + CH_IDX_W'(1) == n_r);
        state_nxt     = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + CH_IDX_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_frame_r  <= 1'b0;
      byte_pos_r  <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_frame_r  <= in_frame_nxt;
      byte_pos_r  <= byte_pos_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = k_r;
  assign out_last_channel  = last_r;

endmodule

// ===== bench/fcfp_frame_checker.sv =====
// ----------------------------------------------------------------------------
// fcfp_frame_checker
// Watches both channels of the float channel frame parser, predicts the
// channel words that each accepted byte releases and compares every emitted
// word against the oldest prediction. Mismatches are counted for the bench.
// ----------------------------------------------------------------------------
module fcfp_frame_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [fcfp_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [fcfp_pkg::CH_IDX_W-1:0] out_channel_index,
  input  logic [fcfp_pkg::WORD_W-1:0]   out_value_bits,
  input  logic                          out_last_channel,
  output int                            fail_count,
  output int                            words_due
);
  import fcfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CH_IDX_W-1:0] idx;
    logic [WORD_W-1:0]   word_bits;
    logic                is_last;
  } chan_word_t;

  // Predicted parser state
  logic              in_frame;
  logic [POS_W-1:0]  frame_pos;
  logic [WORD_W-1:0] frame_words [MAX_CHANNELS];

  // Words released by a terminator, not yet seen on the output
  chan_word_t pending_words [$];

  // Advance the parser by one received byte
  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    int         p;
    int         n;
    chan_word_t w;
    if (b == SYNC_BYTE) begin
      // '$' always (re)opens a frame
      in_frame  = 1'b1;
      frame_pos = '0;
    end else if (in_frame) begin
      p = int'(frame_pos) + 1;
      if (p >= 5 && (p - 1) % LANES == 0 && int'(b) == p) begin
        // terminator: release every stored word
        n         = (p - 1) / LANES;
        in_frame  = 1'b0;
        frame_pos = '0;
        if (n <= MAX_CHANNELS) begin
          for (int k = 0; k < n; k++) begin
            w.idx       = CH_IDX_W'(k);
            w.word_bits = frame_words[k];
            w.is_last   = (k == n - 1);
            pending_words.push_back(w);
          end
        end
      end else if ((p - 1) / LANES >= MAX_CHANNELS) begin
        // buffer full: drop the frame
        in_frame  = 1'b0;
        frame_pos = '0;
      end else begin
        frame_words[(p - 1) / LANES][BYTE_W * ((p - 1) % LANES) +: BYTE_W] = b;
        frame_pos = POS_W'(p);
      end
    end
  endtask

  // Compare one emitted word with the oldest prediction
  task automatic check_word();
    chan_word_t want;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected word: expected none, got idx=%0d bits=%h last=%b",
               $time, out_channel_index, out_value_bits, out_last_channel);
      fail_count++;
    end else begin
      want = pending_words.pop_front();
      if (out_channel_index !== want.idx) begin
        $display("%0t: channel_index: expected %0d, got %0d",
                 $time, want.idx, out_channel_index);
        fail_count++;
      end
      if (out_value_bits !== want.word_bits) begin
        $display("%0t: value_bits (idx %0d): expected %h, got %h",
                 $time, want.idx, want.word_bits, out_value_bits);
        fail_count++;
      end
      if (out_last_channel !== want.is_last) begin
        $display("%0t: last_channel (idx %0d): expected %b, got %b",
                 $time, want.idx, want.is_last, out_last_channel);
        fail_count++;
      end
    end
  endtask

  // Sample both channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_frame  = 1'b0;
      frame_pos = '0;
      pending_words.delete();
    end else begin
      if (out_valid && out_ready) check_word();
      if (in_valid && in_ready) parse_rx_byte(in_rx_byte);
    end
    words_due = pending_words.size();
  end

endmodule

// ===== bench/float_channel_frame_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// float_channel_frame_parser_top_tb
// Feeds the frame parser directed and random byte streams (well-formed
// frames, broken frames, line noise, full and overflowing buffers) with
// random gaps on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module float_channel_frame_parser_top_tb;
  import fcfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 50;
  localparam int TIMEOUT_NS   = 5_000_000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_rx_byte;
  logic                out_valid;
  logic                out_ready;
  logic [CH_IDX_W-1:0] out_channel_index;
  logic [WORD_W-1:0]   out_value_bits;
  logic                out_last_channel;
  int                  fail_count;
  int                  words_due;

  // Sender and receiver coordination
  bit hold_req = 1'b0;
  bit steady   = 1'b0;

  float_channel_frame_parser_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_value_bits    (out_value_bits),
    .out_last_channel  (out_last_channel)
  );

  fcfp_frame_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_value_bits    (out_value_bits),
    .out_last_channel  (out_last_channel),
    .fail_count        (fail_count),
    .words_due         (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Any byte except the frame open marker
  function automatic logic [BYTE_W-1:0] rand_data();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (b == SYNC_BYTE);
    return b;
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // '$', n words of random data, optionally the matching terminator
  task automatic send_frame(input int n_words, input bit with_term);
    send_byte(SYNC_BYTE);
    repeat (LANES * n_words) send_byte(rand_data());
    if (with_term) send_byte(BYTE_W'(LANES * n_words + 1));
  endtask

  // Stop offering until every predicted word has been emitted
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_due != 0);
    @(posedge clk);
  endtask

  // Receiver: random ready pattern, plus a long hold-off on request
  initial begin
    int run;
    int hold_left;
    bit level;
    run       = 0;
    hold_left = 0;
    level     = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (run > 0) begin
          run--;
        end else if (level) begin
          run = pick_gap();
          if (run > 0) level = 1'b0;
        end else begin
          level = 1'b1;
          run   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                               : $urandom_range(40, 100);
        end
        out_ready <= level;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic [BYTE_W-1:0] directed_bytes [26];
    int                rand_items;
    int                r;
    int                k;
    directed_bytes = '{
      // bytes outside any frame
      8'h05, 8'hFF,
      // bytes equal to their position; only 0x05 at position 5 is at a terminator slot and ends the frame
      SYNC_BYTE, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
      // extremes; 0x09 at position 5 is data, at position 9 it ends the frame
      SYNC_BYTE, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h09, 8'hFF, 8'h80, 8'h7F, 8'h09,
      // '$' inside a frame abandons the earlier bytes
      SYNC_BYTE, 8'hAA, SYNC_BYTE, 8'h11, 8'h22, 8'h33, 8'h44, 8'h05
    };
    rand_items = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    wait_drained();

    // Receiver holds off while frames keep coming: burst backs up the input
    hold_req = 1'b1;
    steady   = 1'b1;
    repeat (3) send_frame(2, 1'b1);
    steady = 1'b0;

    // Largest frame, then one byte too many
    send_frame(MAX_CHANNELS, 1'b1);
    send_frame(MAX_CHANNELS, 1'b0);
    send_byte(8'h00);
    send_byte(BYTE_W'(LANES * MAX_CHANNELS + 1));

    // Random mix: mostly well-formed frames, some broken ones and noise
    while (rand_items < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 9) == 0);
      r      = $urandom_range(0, 99);
      if (r < 5) begin
        wait_drained();
      end else if (r < 70) begin
        k = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        send_frame(k, 1'b1);
        rand_items += LANES * k + 2;
      end else if (r < 85) begin
        k = $urandom_range(0, 10);
        send_byte(SYNC_BYTE);
        repeat (k) send_byte(BYTE_W'($urandom));
        rand_items += k + 1;
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(rand_data());
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
